>>> hw/rtl/trc_pkg.sv
// shared types and constants for the tape reader controller
package trc_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned DevW = 7;
  localparam int unsigned WordW = 36;
  localparam int unsigned FrameW = 8;
  localparam int unsigned LevelW = 3;
  localparam int unsigned ShiftW = 6;

  localparam logic [CmdW-1:0] CMD_FRAME  = 3'd0;
  localparam logic [CmdW-1:0] CMD_STATUS = 3'd1;
  localparam logic [CmdW-1:0] CMD_DATAI  = 3'd2;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CmdW-1:0] CMD_SET    = 3'd4;
  localparam logic [CmdW-1:0] CMD_BUSRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_MOTOR  = 3'd6;
  localparam logic [CmdW-1:0] CMD_NOP    = 3'd7;

  localparam logic [DevW-1:0] DEV_CODE_RESET = 7'o104;

  // bit positions in the cono word and status word, and the frame valid bit in a frame
  localparam int unsigned BIT_MOTOR  = 8;
  localparam int unsigned BIT_BINARY = 5;
  localparam int unsigned BIT_BUSY   = 4;
  localparam int unsigned BIT_FLAG   = 3;
  localparam int unsigned BIT_FRAME_VALID = 7;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [WordW-1:0]  bus_data;
    logic [DevW-1:0]   device_code;
    logic [CmdW-1:0]   cmd;
  } item_t;

  typedef struct packed {
    logic              frame_taken;
    logic [LevelW-1:0] interrupt_level;
    logic [WordW-1:0]  read_data;
  } result_t;

endpackage

>>> hw/rtl/trc_core.sv
// controller state and per-beat next-state logic
module trc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_code,
  input  logic             en,
  input  trc_pkg::item_t   item,
  output trc_pkg::result_t result
);

  logic [6:0]  own_code;
  logic        binary_mode, busy_bit, done_flag, motor_running;
  logic [2:0]  priority_level;
  logic [35:0] word_buffer;
  logic [5:0]  strobe_shift;

  logic        binary_mode_next, busy_bit_next, done_flag_next, motor_running_next;
  logic [2:0]  priority_level_next;
  logic [35:0] word_buffer_next;
  logic [5:0]  strobe_shift_next;

  logic        mine;
  logic [35:0] rd;
  logic        taken;

  assign mine = (item.device_code == own_code);

  always_comb begin
    binary_mode_next    = binary_mode;
    busy_bit_next       = busy_bit;
    done_flag_next      = done_flag;
    motor_running_next  = motor_running;
    priority_level_next = priority_level;
    word_buffer_next    = word_buffer;
    strobe_shift_next   = strobe_shift;
    rd    = '0;
    taken = 1'b0;
    unique case (item.cmd)
      trc_pkg::CMD_FRAME: begin
        if (motor_running && busy_bit) begin
          taken = 1'b1;
          if (!(binary_mode && !item.frame[trc_pkg::BIT_FRAME_VALID])) begin
            strobe_shift_next = {strobe_shift[4:0], 1'b1};
            word_buffer_next = {word_buffer[29:0], 6'b0} |
              (binary_mode ? {30'b0, item.frame[5:0]} : {28'b0, item.frame});
            if (!binary_mode || strobe_shift_next[5]) begin
              done_flag_next = 1'b1;
              busy_bit_next  = 1'b0;
            end
          end
        end
      end
      trc_pkg::CMD_STATUS: begin
        if (mine) begin
          rd = {27'b0, motor_running, 2'b0, binary_mode, busy_bit, done_flag,
                priority_level};
        end
      end
      trc_pkg::CMD_DATAI: begin
        if (mine) begin
          rd = word_buffer;
          done_flag_next = 1'b0;
          if (!busy_bit) begin
            busy_bit_next     = 1'b1;
            word_buffer_next  = '0;
            strobe_shift_next = '0;
          end
        end
      end
      trc_pkg::CMD_CLEAR, trc_pkg::CMD_BUSRST: begin
        if (mine || item.cmd == trc_pkg::CMD_BUSRST) begin
          priority_level_next = '0;
          busy_bit_next       = 1'b0;
          done_flag_next      = 1'b0;
          binary_mode_next    = 1'b0;
        end
      end
      trc_pkg::CMD_SET: begin
        if (mine) begin
          if (item.bus_data[trc_pkg::BIT_MOTOR] && !motor_running) begin
            motor_running_next = 1'b1;
            busy_bit_next      = 1'b0;
            done_flag_next     = 1'b1;
          end
          if (item.bus_data[trc_pkg::BIT_BINARY]) binary_mode_next = 1'b1;
          if (item.bus_data[trc_pkg::BIT_BUSY] && !busy_bit_next) begin
            busy_bit_next     = 1'b1;
            word_buffer_next  = '0;
            strobe_shift_next = '0;
          end
          if (item.bus_data[trc_pkg::BIT_FLAG]) done_flag_next = 1'b1;
          priority_level_next = priority_level | item.bus_data[2:0];
        end
      end
      trc_pkg::CMD_MOTOR: begin
        if (motor_running != item.bus_data[0]) begin
          motor_running_next = item.bus_data[0];
          if (item.bus_data[0]) busy_bit_next = 1'b0;
          done_flag_next = 1'b1;
        end
      end
      trc_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign result.read_data       = rd;
  assign result.interrupt_level = done_flag_next ? priority_level_next : 3'b0;
  assign result.frame_taken     = taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_code       <= trc_pkg::DEV_CODE_RESET;
      binary_mode    <= 1'b0;
      busy_bit       <= 1'b0;
      done_flag      <= 1'b0;
      motor_running  <= 1'b0;
      priority_level <= '0;
      word_buffer    <= '0;
      strobe_shift   <= '0;
    end else begin
      if (cfg_we) own_code <= cfg_code;
      if (en) begin
        binary_mode    <= binary_mode_next;
        busy_bit       <= busy_bit_next;
        done_flag      <= done_flag_next;
        motor_running  <= motor_running_next;
        priority_level <= priority_level_next;
        word_buffer    <= word_buffer_next;
        strobe_shift   <= strobe_shift_next;
      end
    end
  end

endmodule

>>> hw/rtl/tape_reader_controller_top.sv
// top level: input register, controller core, result register
// path: a beat is held in the input register, the core computes its result from there, and
// the result is captured in the output register when the output handshake lets it advance
// throughput: one beat per cycle, limited only by the output handshake
// reset: synchronous, clears all controller state, device code returns to 0104
module tape_reader_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,     // own_device_code
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,      // device_code[6:0], bus_data[42:7], frame[50:43], zero fill
  input  logic [2:0]  s_tuser,      // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata       // read_data[35:0], interrupt_level[38:36], frame_taken[39]
);

  logic             in_valid;
  trc_pkg::item_t   in_item;
  logic             advance;
  trc_pkg::result_t core_result;
  trc_pkg::result_t out_result;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.cmd         <= s_tuser;
      in_item.device_code <= s_tdata[6:0];
      in_item.bus_data    <= s_tdata[42:7];
      in_item.frame       <= s_tdata[50:43];
    end
    if (advance) out_result <= core_result;
  end

  trc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_code (cfg_data),
    .en       (advance),
    .item     (in_item),
    .result   (core_result)
  );

  assign m_tdata = {out_result.frame_taken, out_result.interrupt_level,
                    out_result.read_data};

endmodule
